FILE: design/sprite_tile_generator_unit_assert.svh
// Assertion macros for the checker in stg_checker.sv.
`ifndef SPRITE_TILE_GENERATOR_UNIT_ASSERT_SVH
`define SPRITE_TILE_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stg: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define STG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stg: assertion failed");

`endif

FILE: design/stg_pkg.sv
`default_nettype none

package stg_pkg;

  localparam int RAM_BYTES  = 8192;
  localparam int RAM_WORDS  = RAM_BYTES / 2;
  localparam int BYTE_AW    = $clog2(RAM_BYTES);
  localparam int WORD_AW    = $clog2(RAM_WORDS);

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_FRAME = 2'd1;
  localparam logic [1:0] CMD_DRAW  = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_FRAME,
    OP_DRAW
  } op_e;

  localparam logic [BYTE_AW-1:0] SPRITE_BASE = 13'h1d00;

  localparam logic [4:0] TALL_LAST_ROW  = 5'd31;
  localparam logic [4:0] SMALL_LAST_ROW = 5'd1;
  localparam logic [2:0] SMALL_ROW_LOW  = 3'd6;
  localparam logic [7:0] SMALL_HEIGHT   = 8'd16;
  localparam logic [9:0] CHAIN_STEP     = 10'd16;
  localparam logic [9:0] TILE_WIDTH     = 10'd8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    op_e               op;
    logic [BYTE_AW-1:0] addr;
    logic [7:0]        data;
  } q_item_t;

endpackage

`default_nettype wire

FILE: design/stg_front.sv
`default_nettype none

module stg_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire  [1:0]          command_i,
  input  wire  [12:0]         address_i,
  input  wire  [7:0]          write_data_i,
  input  wire  [7:0]          sprite_index_i,
  output logic                push_o,
  output stg_pkg::q_item_t    item_o,
  input  wire                 full_i
);

  logic             item_valid_q;
  stg_pkg::q_item_t item_q;
  stg_pkg::q_item_t item_d;
  logic             keep;
  logic             accept;

  assign in_stall_o = item_valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = item_valid_q;
  assign item_o     = item_q;

  // Commands without meaning are dropped here and never reach the queue.
  always_comb begin
    item_d.data = write_data_i;
    item_d.addr = address_i;
    item_d.op   = stg_pkg::OP_WRITE;
    keep        = 1'b1;
    case (command_i)
      stg_pkg::CMD_WRITE: begin
        item_d.op = stg_pkg::OP_WRITE;
      end
      stg_pkg::CMD_FRAME: begin
        item_d.op = stg_pkg::OP_FRAME;
      end
      stg_pkg::CMD_DRAW: begin
        item_d.op   = stg_pkg::OP_DRAW;
        item_d.addr = stg_pkg::SPRITE_BASE + {3'b000, sprite_index_i, 2'b00};
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (accept) begin
      item_valid_q <= keep;
    end else if (!full_i) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/stg_fifo.sv
`default_nettype none

module stg_fifo (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_i,
  input  stg_pkg::q_item_t  push_item_i,
  output logic              full_o,
  input  wire               pop_i,
  output stg_pkg::q_item_t  pop_item_o,
  output logic              empty_o
);

  stg_pkg::q_item_t                mem_q [stg_pkg::QUEUE_DEPTH];
  logic [stg_pkg::QPTR_W-1:0]      wr_ptr_q;
  logic [stg_pkg::QPTR_W-1:0]      rd_ptr_q;
  logic [stg_pkg::QPTR_W-1:0]      wr_ptr_d;
  logic [stg_pkg::QPTR_W-1:0]      rd_ptr_d;
  logic [stg_pkg::QCNT_W-1:0]      cnt_q;
  logic                            do_push;
  logic                            do_pop;

  assign full_o     = (cnt_q == stg_pkg::QCNT_W'(stg_pkg::QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_item_o = mem_q[rd_ptr_q];

  assign wr_ptr_d = (wr_ptr_q == stg_pkg::QPTR_W'(stg_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
  assign rd_ptr_d = (rd_ptr_q == stg_pkg::QPTR_W'(stg_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_d;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_d;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/stg_back.sv
`default_nettype none

module stg_back (
  input  wire                clk_i,
  input  wire                rst_ni,
  output logic               pop_o,
  input  stg_pkg::q_item_t   item_i,
  input  wire                empty_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic [12:0]        tile_code_o,
  output logic [3:0]         color_o,
  output logic               flip_x_o,
  output logic               flip_y_o,
  output logic signed [9:0]  screen_x_o,
  output logic [7:0]         screen_y_o,
  output logic               last_o
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_HDR_HI  = 2'd1;
  localparam logic [1:0] S_HDR_DEC = 2'd2;
  localparam logic [1:0] S_TILE    = 2'd3;

  // Tile RAM as two byte lanes of one word, even bytes low, odd bytes high.
  logic [7:0] ram_lo [stg_pkg::RAM_WORDS];
  logic [7:0] ram_hi [stg_pkg::RAM_WORDS];
  logic [7:0] rd_lo_q;
  logic [7:0] rd_hi_q;

  logic [1:0]                   state_q;
  logic [1:0]                   state_d;
  logic [9:0]                   chain_q;
  logic                         a_valid_q;
  logic                         out_valid_q;

  logic [stg_pkg::WORD_AW-1:0]  ent_q;
  logic [7:0]                   b1_q;
  logic [9:0]                   x_q;
  logic [7:0]                   y_q;
  logic [2:0]                   bank_q;
  logic [4:0]                   row_q;
  logic                         col_q;

  logic [9:0]                   a_sx_q;
  logic [7:0]                   a_sy_q;
  logic                         a_last_q;
  logic [2:0]                   a_bank_q;

  logic [12:0]                  tile_code_q;
  logic [3:0]                   color_q;
  logic                         flip_x_q;
  logic                         flip_y_q;
  logic [9:0]                   sx_q;
  logic [7:0]                   sy_q;
  logic                         last_q;

  logic                         move;
  logic                         a_free;
  logic                         issue;
  logic                         tall;
  logic [4:0]                   last_row;
  logic                         tile_last;
  logic [1:0]                   page;
  logic [4:0]                   row_base;
  logic [4:0]                   row_sum;
  logic [stg_pkg::WORD_AW-1:0]  tile_word;
  logic                         we;
  logic                         re;
  logic [stg_pkg::WORD_AW-1:0]  rd_addr;
  logic                         pop_draw;
  logic                         pop_frame;
  logic [9:0]                   x_sprite;
  logic [9:0]                   x_new;
  logic [7:0]                   height;

  assign move      = a_valid_q && (!out_valid_q || !out_stall_i);
  assign a_free    = !a_valid_q || move;
  assign issue     = (state_q == S_TILE) && a_free;

  assign tall      = b1_q[7];
  assign last_row  = tall ? stg_pkg::TALL_LAST_ROW : stg_pkg::SMALL_LAST_ROW;
  assign tile_last = col_q && (row_q == last_row);
  assign page      = tall ? b1_q[5:4] : {1'b0, b1_q[4]};
  assign row_base  = tall ? 5'd0 : {b1_q[6:5], stg_pkg::SMALL_ROW_LOW};
  assign row_sum   = row_base + row_q;
  assign tile_word = {page, b1_q[3:0], col_q, row_sum};

  // A draw waits until the last fetched tile has left the read register.
  assign pop_o     = (state_q == S_IDLE) && !empty_i &&
                     ((item_i.op != stg_pkg::OP_DRAW) || !a_valid_q);
  assign we        = pop_o && (item_i.op == stg_pkg::OP_WRITE);
  assign pop_draw  = pop_o && (item_i.op == stg_pkg::OP_DRAW);
  assign pop_frame = pop_o && (item_i.op == stg_pkg::OP_FRAME);

  assign height    = rd_hi_q[7] ? 8'd0 : stg_pkg::SMALL_HEIGHT;
  assign x_sprite  = {rd_hi_q[6] ? 2'b11 : 2'b00, rd_lo_q};
  assign x_new     = (tall && b1_q[6]) ? chain_q + stg_pkg::CHAIN_STEP : x_sprite;

  always_comb begin
    re      = 1'b0;
    rd_addr = item_i.addr[stg_pkg::BYTE_AW-1:1];
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        re = pop_draw;
        if (pop_draw) begin
          state_d = S_HDR_HI;
        end
      end
      S_HDR_HI: begin
        re      = 1'b1;
        rd_addr = ent_q;
        state_d = S_HDR_DEC;
      end
      S_HDR_DEC: begin
        state_d = S_TILE;
      end
      S_TILE: begin
        re      = issue;
        rd_addr = tile_word;
        if (issue && tile_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we && !item_i.addr[0]) begin
      ram_lo[item_i.addr[stg_pkg::BYTE_AW-1:1]] <= item_i.data;
    end
    if (we && item_i.addr[0]) begin
      ram_hi[item_i.addr[stg_pkg::BYTE_AW-1:1]] <= item_i.data;
    end
    if (re) begin
      rd_lo_q <= ram_lo[rd_addr];
      rd_hi_q <= ram_hi[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      chain_q     <= '0;
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_frame) begin
        chain_q <= '0;
      end else if (state_q == S_HDR_DEC) begin
        chain_q <= x_new;
      end
      if (issue) begin
        a_valid_q <= 1'b1;
      end else if (move) begin
        a_valid_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_draw) begin
      ent_q <= {item_i.addr[stg_pkg::BYTE_AW-1:2], 1'b1};
    end
    if (state_q == S_HDR_HI) begin
      b1_q <= rd_hi_q;
      y_q  <= 8'd0 - rd_lo_q - height;
    end
    if (state_q == S_HDR_DEC) begin
      x_q    <= x_new;
      bank_q <= rd_hi_q[2:0];
      row_q  <= '0;
      col_q  <= 1'b0;
    end
    if (issue) begin
      col_q    <= !col_q;
      if (col_q) begin
        row_q <= row_q + 5'd1;
      end
      a_sx_q   <= x_q + (col_q ? stg_pkg::TILE_WIDTH : 10'd0);
      a_sy_q   <= y_q + {row_q, 3'b000};
      a_last_q <= tile_last;
      a_bank_q <= bank_q;
    end
    if (move) begin
      tile_code_q <= {a_bank_q, rd_hi_q[1:0], rd_lo_q};
      color_q     <= rd_hi_q[5:2];
      flip_x_q    <= rd_hi_q[6];
      flip_y_q    <= rd_hi_q[7];
      sx_q        <= a_sx_q;
      sy_q        <= a_sy_q;
      last_q      <= a_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign tile_code_o = tile_code_q;
  assign color_o     = color_q;
  assign flip_x_o    = flip_x_q;
  assign flip_y_o    = flip_y_q;
  assign screen_x_o  = signed'(sx_q);
  assign screen_y_o  = sy_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

FILE: design/sprite_tile_generator_unit.sv
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_stall_o  command, address, write_data, sprite_index
// out       output     out_valid_o / out_stall_i tile_code, color, flip_x, flip_y,
//                                               screen_x, screen_y, last
//
// Writes and frame starts are completed by the back end as they leave the queue.
// A draw reads its entry in S_IDLE and S_HDR_HI and decodes it in S_HDR_DEC, then fetches one
// tile per cycle unless the output stalls, set by the single tile RAM read port (2x2 or 2x32 tiles).
// A draw that follows another waits for the last tile to leave the read register.
// Reset empties the queue and clears the chain X; tile RAM contents are not reset.
// A stalled output holds one tile and one more waits in the read register before fetching stops.
`default_nettype none

module sprite_tile_generator_unit (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire  [1:0]        command_i,
  input  wire  [12:0]       address_i,
  input  wire  [7:0]        write_data_i,
  input  wire  [7:0]        sprite_index_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic [12:0]       tile_code_o,
  output logic [3:0]        color_o,
  output logic              flip_x_o,
  output logic              flip_y_o,
  output logic signed [9:0] screen_x_o,
  output logic [7:0]        screen_y_o,
  output logic              last_o
);

  logic             push;
  stg_pkg::q_item_t push_item;
  logic             full;
  logic             pop;
  stg_pkg::q_item_t pop_item;
  logic             empty;

  stg_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .address_i      (address_i),
    .write_data_i   (write_data_i),
    .sprite_index_i (sprite_index_i),
    .push_o         (push),
    .item_o         (push_item),
    .full_i         (full)
  );

  stg_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .empty_o     (empty)
  );

  stg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_o       (pop),
    .item_i      (pop_item),
    .empty_i     (empty),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .tile_code_o (tile_code_o),
    .color_o     (color_o),
    .flip_x_o    (flip_x_o),
    .flip_y_o    (flip_y_o),
    .screen_x_o  (screen_x_o),
    .screen_y_o  (screen_y_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

FILE: design/stg_checker.sv
`default_nettype none
`include "sprite_tile_generator_unit_assert.svh"

module stg_checker (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  input  wire              in_stall_o,
  input  wire [1:0]        command_i,
  input  wire [12:0]       address_i,
  input  wire [7:0]        write_data_i,
  input  wire [7:0]        sprite_index_i,
  input  wire              out_valid_o,
  input  wire              out_stall_i,
  input  wire [12:0]       tile_code_o,
  input  wire [3:0]        color_o,
  input  wire              flip_x_o,
  input  wire              flip_y_o,
  input  wire signed [9:0] screen_x_o,
  input  wire [7:0]        screen_y_o,
  input  wire              last_o
);

  // A stalled item stays offered.
  `STG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // A stalled item keeps its payload.
  `STG_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(tile_code_o) && $stable(color_o) && $stable(flip_x_o) && $stable(flip_y_o) && $stable(screen_x_o) && $stable(screen_y_o) && $stable(last_o))

  // Within a sprite the next tile is always ready behind the one taken.
  `STG_ASSERT_NEXT(a_tile_stream, clk_i, rst_ni, out_valid_o && !out_stall_i && !last_o, out_valid_o)

  // The input stalls only while holding an item it has already taken.
  `STG_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, in_stall_o, $past(in_stall_o) || $past(in_valid_i))

endmodule

bind sprite_tile_generator_unit stg_checker u_checker (.*);

`default_nettype wire

FILE: tb/sprite_tile_checker.sv
`timescale 1ns / 100ps

module sprite_tile_checker
  import stg_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  input  wire        in_stall_i,
  input  wire  [1:0] command_i,
  input  wire  [12:0] address_i,
  input  wire  [7:0] write_data_i,
  input  wire  [7:0] sprite_index_i,
  input  wire        out_valid_i,
  input  wire        out_stall_i,
  input  wire  [12:0] tile_code_i,
  input  wire  [3:0] color_i,
  input  wire        flip_x_i,
  input  wire        flip_y_i,
  input  wire  [9:0] screen_x_i,
  input  wire  [7:0] screen_y_i,
  input  wire        last_i,
  output int         pending_o,
  output int         fail_count_o
);

  typedef struct packed {
    logic [12:0] code;
    logic [3:0]  color;
    logic        flip_x;
    logic        flip_y;
    logic [9:0]  x;
    logic [7:0]  y;
    logic        last;
  } tile_draw_t;

  logic [7:0]  ram_copy [RAM_BYTES];
  logic [9:0]  chain_x = '0;
  tile_draw_t  draws_due [$];

  task automatic expand_sprite(input logic [7:0] index);
    logic [12:0] at;
    logic [7:0]  b0, b1, b2, b3, tile, attr;
    logic [4:0]  col, row;
    logic [1:0]  page;
    logic [11:0] word;
    logic [9:0]  x;
    logic [7:0]  y;
    int          rows;
    tile_draw_t  d;
    at = SPRITE_BASE + {3'b000, index, 2'b00};
    b0 = ram_copy[at];
    b1 = ram_copy[at + 13'd1];
    b2 = ram_copy[at + 13'd2];
    b3 = ram_copy[at + 13'd3];
    col = {b1[3:0], 1'b0};
    if (b1[7]) begin
      rows = 32;
      row = 5'd0;
      page = b1[5:4];
    end else begin
      rows = 2;
      row = {b1[6:5], SMALL_ROW_LOW};
      page = {1'b0, b1[4]};
    end
    x = {2'b00, b2};
    if (b3[6]) x = x - 10'h100;
    y = 8'h00 - b0 - 8'(rows * 8);
    // A chained tall sprite sits one step to the right of the previous sprite.
    if (b1[7] && b1[6]) begin
      chain_x = chain_x + CHAIN_STEP;
      x = chain_x;
    end else begin
      chain_x = x;
    end
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < 2; c++) begin
        word = {page, 5'(col + c), 5'(row + r)};
        tile = ram_copy[{word, 1'b0}];
        attr = ram_copy[{word, 1'b1}];
        d.code = {5'b00000, tile} + {3'b000, attr[1:0], 8'h00} + {b3[2:0], 10'h000};
        d.color = attr[5:2];
        d.flip_x = attr[6];
        d.flip_y = attr[7];
        d.x = x + 10'(c * 8);
        d.y = y + 8'(r * 8);
        d.last = (r == rows - 1) && (c == 1);
        draws_due.push_back(d);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    tile_draw_t got, want;
    if (!rst_ni) begin
      chain_x = '0;
      draws_due.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = {tile_code_i, color_i, flip_x_i, flip_y_i, screen_x_i, screen_y_i, last_i};
        if (draws_due.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("%0t: unexpected tile draw code %h color %h fx %b fy %b x %h y %h last %b",
                     $time, got.code, got.color, got.flip_x, got.flip_y, got.x, got.y,
                     got.last);
          end
          fail_count_o = fail_count_o + 1;
        end else begin
          want = draws_due.pop_front();
          if (got !== want) begin
            if (fail_count_o < 10) begin
              $display("%0t: tile draw mismatch", $time);
              $display("  expected code %h color %h fx %b fy %b x %h y %h last %b",
                       want.code, want.color, want.flip_x, want.flip_y, want.x, want.y,
                       want.last);
              $display("  actual   code %h color %h fx %b fy %b x %h y %h last %b",
                       got.code, got.color, got.flip_x, got.flip_y, got.x, got.y, got.last);
            end
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (command_i)
          CMD_WRITE: ram_copy[address_i] = write_data_i;
          CMD_FRAME: chain_x = '0;
          CMD_DRAW:  expand_sprite(sprite_index_i);
          default: ;
        endcase
      end
    end
    pending_o = draws_due.size();
  end

endmodule

FILE: tb/sprite_tile_generator_unit_tb.sv
`timescale 1ns / 100ps

module sprite_tile_generator_unit_tb;
  import stg_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int LONG_HOLD     = 400;
  localparam int DRAIN_CYCLES  = 100;
  localparam int RANDOM_ROUNDS = 28;
  localparam int HOLD_AT       = 19;
  localparam int BURST         = 8;

  // The tall sprite area is page 3, columns 20 and 21, which also holds entries 0 to 31.
  localparam logic [12:0] TALL_AREA  = 13'h1d00;
  localparam int          TALL_BYTES = 128;
  localparam int          SPRITES    = 32;
  // The small sprite area is page 0, columns 2 and 3, rows 30 and 31, which also holds
  // the wrapped entries 239 and 255.
  localparam logic [12:0] SMALL_LO   = 13'h00bc;
  localparam logic [12:0] SMALL_HI   = 13'h00fc;
  localparam logic [7:0]  WRAP_LO    = 8'd239;
  localparam logic [7:0]  WRAP_HI    = 8'd255;
  localparam logic [7:0]  B1_TALL    = 8'hba;
  localparam logic [7:0]  B1_CHAIN   = 8'hfa;
  localparam logic [7:0]  B1_SMALL   = 8'h61;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  wire               in_stall_o;
  logic [1:0]        command_i = CMD_WRITE;
  logic [12:0]       address_i = '0;
  logic [7:0]        write_data_i = '0;
  logic [7:0]        sprite_index_i = '0;
  wire               out_valid_o;
  logic              out_stall_i = 1'b0;
  wire [12:0]        tile_code_o;
  wire [3:0]         color_o;
  wire               flip_x_o;
  wire               flip_y_o;
  wire signed [9:0]  screen_x_o;
  wire [7:0]         screen_y_o;
  wire               last_o;

  int   pending;
  int   fail_count;
  int   cycles = 0;
  int   snd_idle = 6;
  int   rcv_idle = 46;
  int   hold_left = 0;
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;

  sprite_tile_generator_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .address_i      (address_i),
    .write_data_i   (write_data_i),
    .sprite_index_i (sprite_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .tile_code_o    (tile_code_o),
    .color_o        (color_o),
    .flip_x_o       (flip_x_o),
    .flip_y_o       (flip_y_o),
    .screen_x_o     (screen_x_o),
    .screen_y_o     (screen_y_o),
    .last_o         (last_o)
  );

  sprite_tile_checker tile_draw_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .command_i      (command_i),
    .address_i      (address_i),
    .write_data_i   (write_data_i),
    .sprite_index_i (sprite_index_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .tile_code_i    (tile_code_o),
    .color_i        (color_o),
    .flip_x_i       (flip_x_o),
    .flip_y_i       (flip_y_o),
    .screen_x_i     (screen_x_o),
    .screen_y_i     (screen_y_o),
    .last_i         (last_o),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** sprite_tile_generator_unit: FAILED **");
      $finish;
    end
  end

  // The long hold-off starts whenever the stimulus flips hold_toggle.
  always @(negedge clk_i) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= LONG_HOLD;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rcv_idle);
    end
  end

  // Every sprite entry that can be drawn reads only bytes that were written before.
  function automatic logic [7:0] pick_b1();
    logic [7:0] b1;
    case ($urandom_range(2))
      0: b1 = B1_TALL;
      1: b1 = B1_CHAIN;
      default: b1 = B1_SMALL;
    endcase
    return b1;
  endfunction

  function automatic logic [7:0] pick_slot();
    logic [7:0] s;
    s = 8'($urandom_range(SPRITES - 1));
    if ($urandom_range(7) == 0) begin
      s = ($urandom_range(1) == 0) ? WRAP_LO : WRAP_HI;
    end
    return s;
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [12:0] addr,
                           input logic [7:0] data, input logic [7:0] index);
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    address_i <= addr;
    write_data_i <= data;
    sprite_index_i <= index;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  initial begin
    int pick;
    logic [12:0] wa;
    logic [7:0]  wd;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int a = 0; a < TALL_BYTES; a++) begin
      wa = TALL_AREA + 13'(a);
      wd = (wa[1:0] == 2'b01) ? pick_b1() : 8'($urandom);
      send_item(CMD_WRITE, wa, wd, 8'($urandom));
    end
    for (int a = 0; a < 8; a++) begin
      wa = (a < 4) ? SMALL_LO + 13'(a) : SMALL_HI + 13'(a - 4);
      wd = (wa[1:0] == 2'b01) ? B1_SMALL : 8'($urandom);
      send_item(CMD_WRITE, wa, wd, 8'($urandom));
    end

    send_item(CMD_FRAME, 13'h1fff, 8'hff, 8'hff);
    send_item(CMD_UNUSED, 13'h1fff, 8'hff, 8'hff);
    // A tall sprite at X = -8 followed by chained ones wraps the chain X.
    send_item(CMD_WRITE, TALL_AREA + 13'd5, B1_CHAIN, 8'h00);
    send_item(CMD_WRITE, TALL_AREA + 13'd8, 8'h00, 8'h00);
    send_item(CMD_WRITE, TALL_AREA + 13'd9, B1_TALL, 8'h00);
    send_item(CMD_WRITE, TALL_AREA + 13'd10, 8'hf8, 8'h00);
    send_item(CMD_WRITE, TALL_AREA + 13'd11, 8'h47, 8'h00);
    send_item(CMD_DRAW, 13'h0000, 8'h00, 8'd2);
    send_item(CMD_DRAW, 13'h1fff, 8'hff, 8'd1);
    send_item(CMD_DRAW, 13'h0aaa, 8'h55, 8'd1);
    send_item(CMD_FRAME, 13'h0000, 8'h00, 8'h00);
    send_item(CMD_DRAW, 13'h1555, 8'haa, 8'd1);
    send_item(CMD_DRAW, 13'h0000, 8'h00, WRAP_HI);
    send_item(CMD_DRAW, 13'h0000, 8'h00, WRAP_LO);

    for (int n = 0; n < RANDOM_ROUNDS; n++) begin
      if (n == RANDOM_ROUNDS / 3) begin
        snd_idle = 46;
        rcv_idle <= 6;
      end
      if (n == 2 * RANDOM_ROUNDS / 3) begin
        snd_idle = 0;
        rcv_idle <= 0;
      end
      if (n == HOLD_AT) hold_toggle <= ~hold_toggle;
      if (n == HOLD_AT + BURST) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
        while (pending != 0) @(negedge clk_i);
      end
      pick = $urandom_range(99);
      if (n >= HOLD_AT && n < HOLD_AT + BURST) pick = 0;
      if (pick < 55) begin
        send_item(CMD_DRAW, 13'($urandom), 8'($urandom), pick_slot());
      end else if (pick < 70) begin
        send_item(CMD_FRAME, 13'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 90) begin
        // Sprite entry byte 1 is left alone so every entry stays drawable.
        wa = {6'b111010, 7'($urandom)};
        if (wa[1:0] == 2'b01) wa[1] = 1'b1;
        send_item(CMD_WRITE, wa, 8'($urandom), 8'($urandom));
      end else begin
        send_item(CMD_UNUSED, 13'($urandom), 8'($urandom), 8'($urandom));
      end
    end

    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("** sprite_tile_generator_unit: PASSED **");
    end else begin
      $display("** sprite_tile_generator_unit: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/stg_pkg.sv
design/stg_front.sv
design/stg_fifo.sv
design/stg_back.sv
design/sprite_tile_generator_unit.sv
design/stg_checker.sv
tb/sprite_tile_checker.sv
tb/sprite_tile_generator_unit_tb.sv
